// ===== rtl/vwap_pkg.sv =====
package vwap_pkg;

  localparam int unsigned REG_IDX_W = 8;

  // register indexes on the configuration channel
  localparam logic [REG_IDX_W-1:0] REG_TRACKED_SYMBOL = 8'd0;
  localparam logic [REG_IDX_W-1:0] REG_ORDER_SIDE     = 8'd1;
  localparam logic [REG_IDX_W-1:0] REG_ORDER_SIZE_CAP = 8'd2;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_SECONDS = 8'd3;

  localparam logic [7:0]  PKT_QUOTE     = 8'd1;
  localparam logic        SIDE_BUY      = 1'b0;
  localparam logic        SIDE_SELL     = 1'b1;
  localparam logic [29:0] NS_PER_SECOND = 30'd1000000000;

  typedef struct packed {
    logic [7:0]  packet_length;
    logic [7:0]  packet_type;
    logic [63:0] packet_symbol;
    logic [63:0] packet_timestamp;
    logic [31:0] quote_bid_size;
    logic [31:0] quote_bid_px;
    logic [31:0] quote_ask_size;
    logic [31:0] quote_ask_px;
    logic [31:0] trade_quantity;
    logic [31:0] trade_price;
  } packet_t;

  typedef struct packed {
    logic [63:0] order_symbol;
    logic [63:0] order_timestamp;
    logic        order_is_sell;
    logic [31:0] order_quantity;
    logic [31:0] order_price;
  } order_t;

  typedef struct packed {
    logic [REG_IDX_W-1:0] reg_index;
    logic [63:0]          reg_data;
  } cfg_t;

endpackage

// ===== rtl/vwap_chan_if.sv =====
interface vwap_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/vwap_window_order_trigger_unit.sv =====
// volume-weighted average price window trigger
// channels (valid/ready, a word moves when both are high at a rising edge):
//   cfg       : register writes {reg_index, reg_data}; always ready. the user
//               writes only while no packet is in flight (not enforced)
//   packet_in : one decoded market-data packet per word
//   order_out : at most one order per packet
// a packet's order (if any) passes stage registers s1 to s5, then shows as
// order_out.valid. one packet is taken every cycle while the skid register
// is empty, through the five-stage pipe: input register, product of the
// trade, window/sum update, two 32-bit partial products of the price test,
// compare, then the held quantity update feeding the output register.
// when order_out stalls, one more order parks in a skid register; while that
// register is full the whole pipe holds and packet_in.ready is low.
// reset (rst, synchronous) zeroes config, sums, window and held quote and
// quantities, and empties the pipe; the pipe's data registers keep values.
module vwap_window_order_trigger_unit (
  input  logic         clk,
  input  logic         rst,
  vwap_chan_if.sink    cfg,
  vwap_chan_if.sink    packet_in,
  vwap_chan_if.source  order_out
);

  // configuration
  logic [63:0] tracked_symbol;
  logic        order_side;
  logic [31:0] order_size_cap;
  logic [61:0] window_ns;

  // pipe control
  logic adv;
  logic accept;

  // stage 1: input register
  logic        s1_valid;
  logic [63:0] s1_symbol, s1_ts;
  logic [7:0]  s1_type;
  logic [31:0] s1_bid_q, s1_bid_px, s1_ask_q, s1_ask_px, s1_trade_q, s1_trade_px;

  // stage 2: window and sums
  logic        s2_valid;
  logic [63:0] s2_symbol, s2_ts, s2_prod;
  logic [7:0]  s2_type;
  logic [31:0] s2_bid_q, s2_bid_px, s2_ask_q, s2_ask_px, s2_trade_q;

  logic        quote_held, trade_seen, window_started;
  logic [31:0] bid_px, ask_px;
  logic [63:0] pv_sum, vol_sum, window_start;

  logic        match, q_upd, t_upd;
  logic [64:0] pv_add, vol_add;
  logic [63:0] pv_acc, vol_acc, start_eff, elapsed;
  logic        fire;
  logic        quote_held_next, trade_seen_next;
  logic [31:0] bid_px_next, ask_px_next;
  logic [63:0] pv_sum_next, vol_sum_next, window_start_next;

  // stage 3: partial products
  logic        s3_valid, s3_fire, s3_q_upd;
  logic [63:0] s3_pv, s3_vol, s3_ts;
  logic [31:0] s3_price, s3_bid_q, s3_ask_q;
  logic [32:0] s3_mult;

  // stage 4: compare
  logic        s4_valid, s4_fire, s4_q_upd, s4_vol_nz;
  logic [63:0] s4_pv, s4_ts;
  logic [64:0] s4_lo, s4_hi;
  logic [31:0] s4_price, s4_bid_q, s4_ask_q;
  logic [96:0] s4_full;
  logic        s4_better;

  // stage 5: held quantities and the order
  logic        s5_valid, s5_hit, s5_q_upd;
  logic [63:0] s5_ts;
  logic [31:0] s5_price, s5_bid_q, s5_ask_q;
  logic [31:0] bid_qty, ask_qty;
  logic [31:0] bid_qty_cur, ask_qty_cur, qty, sent, remain;
  logic        emit, push;
  vwap_pkg::order_t result;

  // output register and skid
  logic             skid_valid;
  vwap_pkg::order_t skid;

  assign adv             = !skid_valid;
  assign accept          = packet_in.valid && adv;
  assign packet_in.ready = adv;
  assign cfg.ready       = 1'b1;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      tracked_symbol <= '0;
      order_side     <= vwap_pkg::SIDE_BUY;
      order_size_cap <= '0;
      window_ns      <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.data.reg_index)
        vwap_pkg::REG_TRACKED_SYMBOL: tracked_symbol <= cfg.data.reg_data;
        vwap_pkg::REG_ORDER_SIDE:     order_side     <= cfg.data.reg_data[0];
        vwap_pkg::REG_ORDER_SIZE_CAP: order_size_cap <= cfg.data.reg_data[31:0];
        vwap_pkg::REG_WINDOW_SECONDS:
          window_ns <= 62'(cfg.data.reg_data[31:0]) * 62'(vwap_pkg::NS_PER_SECOND);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else if (adv) begin
      // zero-length packets are dropped at the door
      s1_valid <= accept && (packet_in.data.packet_length != 8'd0);
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
    end
  end

  // ---------------------------------------------------------------- stage 1
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_symbol   <= packet_in.data.packet_symbol;
      s1_ts       <= packet_in.data.packet_timestamp;
      s1_type     <= packet_in.data.packet_type;
      s1_bid_q    <= packet_in.data.quote_bid_size;
      s1_bid_px   <= packet_in.data.quote_bid_px;
      s1_ask_q    <= packet_in.data.quote_ask_size;
      s1_ask_px   <= packet_in.data.quote_ask_px;
      s1_trade_q  <= packet_in.data.trade_quantity;
      s1_trade_px <= packet_in.data.trade_price;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_symbol  <= s1_symbol;
      s2_ts      <= s1_ts;
      s2_type    <= s1_type;
      s2_bid_q   <= s1_bid_q;
      s2_bid_px  <= s1_bid_px;
      s2_ask_q   <= s1_ask_q;
      s2_ask_px  <= s1_ask_px;
      s2_trade_q <= s1_trade_q;
      s2_prod    <= 64'(s1_trade_px) * 64'(s1_trade_q);
    end
  end

  // ---------------------------------------------------------------- stage 2
  always_comb begin
    match = (s2_symbol == tracked_symbol);
    q_upd = match && (s2_type == vwap_pkg::PKT_QUOTE);
    t_upd = match && (s2_type != vwap_pkg::PKT_QUOTE);

    bid_px_next     = q_upd ? s2_bid_px : bid_px;
    ask_px_next     = q_upd ? s2_ask_px : ask_px;
    quote_held_next = quote_held || q_upd;
    trade_seen_next = trade_seen || t_upd;

    // saturating sums
    pv_add  = {1'b0, pv_sum} + {1'b0, s2_prod};
    vol_add = {1'b0, vol_sum} + {33'd0, s2_trade_q};
    pv_acc  = pv_sum;
    vol_acc = vol_sum;
    if (t_upd) begin
      pv_acc  = pv_add[64]  ? '1 : pv_add[63:0];
      vol_acc = vol_add[64] ? '1 : vol_add[63:0];
    end

    start_eff = window_started ? window_start : s2_ts;
    elapsed   = s2_ts - start_eff;
    fire      = quote_held_next && trade_seen_next && (elapsed >= {2'b00, window_ns});

    pv_sum_next       = fire ? '0 : pv_acc;
    vol_sum_next      = fire ? '0 : vol_acc;
    window_start_next = fire ? s2_ts : start_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_held     <= 1'b0;
      trade_seen     <= 1'b0;
      window_started <= 1'b0;
      bid_px         <= '0;
      ask_px         <= '0;
      pv_sum         <= '0;
      vol_sum        <= '0;
      window_start   <= '0;
    end else if (adv && s2_valid) begin
      quote_held     <= quote_held_next;
      trade_seen     <= trade_seen_next;
      window_started <= 1'b1;
      bid_px         <= bid_px_next;
      ask_px         <= ask_px_next;
      pv_sum         <= pv_sum_next;
      vol_sum        <= vol_sum_next;
      window_start   <= window_start_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_fire  <= fire;
      s3_q_upd <= q_upd;
      s3_pv    <= pv_acc;
      s3_vol   <= vol_acc;
      s3_ts    <= s2_ts;
      s3_price <= (order_side == vwap_pkg::SIDE_SELL) ? bid_px_next : ask_px_next;
      s3_bid_q <= s2_bid_q;
      s3_ask_q <= s2_ask_q;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // buy:  ask < floor(pv/vol)  <=>  (ask + 1) * vol <= pv
  // sell: bid > floor(pv/vol)  <=>  bid * vol > pv
  assign s3_mult = (order_side == vwap_pkg::SIDE_SELL) ? {1'b0, s3_price}
                                                       : {1'b0, s3_price} + 33'd1;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_lo     <= 65'(s3_mult) * 65'(s3_vol[31:0]);
      s4_hi     <= 65'(s3_mult) * 65'(s3_vol[63:32]);
      s4_fire   <= s3_fire;
      s4_q_upd  <= s3_q_upd;
      s4_vol_nz <= (s3_vol != '0);
      s4_pv     <= s3_pv;
      s4_ts     <= s3_ts;
      s4_price  <= s3_price;
      s4_bid_q  <= s3_bid_q;
      s4_ask_q  <= s3_ask_q;
    end
  end

  // ---------------------------------------------------------------- stage 4
  always_comb begin
    s4_full = {s4_hi, 32'd0} + {32'd0, s4_lo};
    if (order_side == vwap_pkg::SIDE_SELL) begin
      s4_better = s4_full > {33'd0, s4_pv};
    end else begin
      s4_better = s4_full <= {33'd0, s4_pv};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_hit   <= s4_fire && s4_vol_nz && s4_better;
      s5_q_upd <= s4_q_upd;
      s5_ts    <= s4_ts;
      s5_price <= s4_price;
      s5_bid_q <= s4_bid_q;
      s5_ask_q <= s4_ask_q;
    end
  end

  // ---------------------------------------------------------------- stage 5
  always_comb begin
    bid_qty_cur = s5_q_upd ? s5_bid_q : bid_qty;
    ask_qty_cur = s5_q_upd ? s5_ask_q : ask_qty;
    qty         = (order_side == vwap_pkg::SIDE_SELL) ? bid_qty_cur : ask_qty_cur;
    emit        = s5_hit && (qty != '0);
    sent        = (qty < order_size_cap) ? qty : order_size_cap;
    remain      = qty - sent;
    push        = adv && s5_valid && emit;

    result.order_symbol    = tracked_symbol;
    result.order_timestamp = s5_ts;
    result.order_is_sell   = order_side;
    result.order_quantity  = sent;
    result.order_price     = s5_price;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bid_qty <= '0;
      ask_qty <= '0;
    end else if (adv && s5_valid) begin
      bid_qty <= (emit && order_side == vwap_pkg::SIDE_SELL) ? remain : bid_qty_cur;
      ask_qty <= (emit && order_side == vwap_pkg::SIDE_BUY)  ? remain : ask_qty_cur;
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (rst) begin
      order_out.valid <= 1'b0;
      skid_valid      <= 1'b0;
    end else if (!order_out.valid || order_out.ready) begin
      if (skid_valid) begin
        order_out.valid <= 1'b1;
        skid_valid      <= 1'b0;
      end else begin
        order_out.valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!order_out.valid || order_out.ready) begin
      if (skid_valid) begin
        order_out.data <= skid;
      end else if (push) begin
        order_out.data <= result;
      end
    end else if (push) begin
      skid <= result;
    end
  end

  // ---------------------------------------------------------------- checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> order_out.valid)
    else $error("skid word held with output register empty");

  a_sums_clear_on_fire: assert property (@(posedge clk) disable iff (rst)
    (adv && s2_valid && fire) |=> (vol_sum == '0 && pv_sum == '0))
    else $error("sums not cleared at window expiry");

  a_window_opens: assert property (@(posedge clk) disable iff (rst)
    (adv && s2_valid) |=> window_started)
    else $error("window not open after a packet");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int IDLE_LIMIT  = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 12;

  logic clk = 1'b0;
  logic rst = 1'b1;

  vwap_chan_if #(.T(vwap_pkg::cfg_t))    cfg_ch ();
  vwap_chan_if #(.T(vwap_pkg::packet_t)) pkt_ch ();
  vwap_chan_if #(.T(vwap_pkg::order_t))  ord_ch ();

  vwap_window_order_trigger_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_ch),
    .packet_in (pkt_ch),
    .order_out (ord_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the registers
  logic [63:0] trk_symbol = '0;
  logic        sell_side  = vwap_pkg::SIDE_BUY;
  logic [31:0] qty_cap    = '0;
  logic [63:0] window_ns  = '0;

  // predictor copy of the window state
  logic        have_quote  = 1'b0;
  logic [31:0] q_bid_qty   = '0;
  logic [31:0] q_bid_px    = '0;
  logic [31:0] q_ask_qty   = '0;
  logic [31:0] q_ask_px    = '0;
  logic        saw_trade   = 1'b0;
  logic [63:0] px_vol_sum  = '0;
  logic [63:0] qty_sum     = '0;
  logic        window_open = 1'b0;
  logic [63:0] window_t0   = '0;

  vwap_pkg::packet_t packet_queue[$];
  vwap_pkg::order_t  expected_orders[$];
  int      packets_sent  = 0;
  int      packets_taken = 0;
  int      errors        = 0;
  int      idle_cycles   = 0;
  bit      calm          = 1'b0;
  bit      hold_request  = 1'b0;
  logic [63:0] stamp_now = '0;
  logic [63:0] ts_span   = 64'd1000;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  function automatic void predict_order(input vwap_pkg::packet_t p);
    logic [63:0] elapsed;
    logic [63:0] vwap;
    logic [31:0] px;
    logic [31:0] qty;
    logic [31:0] sent;
    logic        better;
    vwap_pkg::order_t o;
    if (p.packet_length == 8'd0) return;
    if (p.packet_symbol == trk_symbol) begin
      if (p.packet_type == vwap_pkg::PKT_QUOTE) begin
        q_bid_qty  = p.quote_bid_size;
        q_bid_px   = p.quote_bid_px;
        q_ask_qty  = p.quote_ask_size;
        q_ask_px   = p.quote_ask_px;
        have_quote = 1'b1;
      end else begin
        px_vol_sum = sat_add(px_vol_sum, 64'(p.trade_price) * 64'(p.trade_quantity));
        qty_sum    = sat_add(qty_sum, 64'(p.trade_quantity));
        saw_trade  = 1'b1;
      end
    end
    if (!window_open) begin
      window_open = 1'b1;
      window_t0   = p.packet_timestamp;
    end
    elapsed = p.packet_timestamp - window_t0;
    if (!(have_quote && saw_trade && elapsed >= window_ns)) return;
    // empty sums still close the window
    if (qty_sum != 64'd0) begin
      vwap = px_vol_sum / qty_sum;
      if (sell_side == vwap_pkg::SIDE_BUY) begin
        px     = q_ask_px;
        qty    = q_ask_qty;
        better = 64'(px) < vwap;
      end else begin
        px     = q_bid_px;
        qty    = q_bid_qty;
        better = 64'(px) > vwap;
      end
      if (qty != 32'd0 && better) begin
        sent              = (qty < qty_cap) ? qty : qty_cap;
        o.order_symbol    = trk_symbol;
        o.order_timestamp = p.packet_timestamp;
        o.order_is_sell   = sell_side;
        o.order_quantity  = sent;
        o.order_price     = px;
        expected_orders.push_back(o);
        if (sell_side == vwap_pkg::SIDE_BUY) q_ask_qty = qty - sent;
        else q_bid_qty = qty - sent;
      end
    end
    px_vol_sum = '0;
    qty_sum    = '0;
    window_t0  = p.packet_timestamp;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: order mismatch on %s: got %h, expected %h", $time, what, got, want);
    errors++;
  endtask

  // packet driver
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      pkt_ch.valid <= 1'b0;
      pkt_ch.data  <= '0;
      gap_left = 0;
    end else begin
      if (pkt_ch.valid && pkt_ch.ready) begin
        predict_order(pkt_ch.data);
        packets_taken++;
        gap_left = calm ? 0 : $urandom_range(0, 8);
      end
      if (!pkt_ch.valid || pkt_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          pkt_ch.valid <= 1'b0;
        end else if (packet_queue.size() != 0) begin
          pkt_ch.valid <= 1'b1;
          pkt_ch.data  <= packet_queue.pop_front();
        end else begin
          pkt_ch.valid <= 1'b0;
        end
      end
    end
  end

  // order monitor
  int stall_left = 0;
  int hold_left  = 0;
  always @(posedge clk) begin
    vwap_pkg::order_t got;
    vwap_pkg::order_t want;
    if (rst) begin
      ord_ch.ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (ord_ch.valid && ord_ch.ready) begin
        got = ord_ch.data;
        if (expected_orders.size() == 0) begin
          report_mismatch("unexpected order timestamp", got.order_timestamp, '0);
        end else begin
          want = expected_orders.pop_front();
          if (got.order_symbol !== want.order_symbol)
            report_mismatch("order_symbol", got.order_symbol, want.order_symbol);
          if (got.order_timestamp !== want.order_timestamp)
            report_mismatch("order_timestamp", got.order_timestamp, want.order_timestamp);
          if (got.order_is_sell !== want.order_is_sell)
            report_mismatch("order_is_sell", 64'(got.order_is_sell), 64'(want.order_is_sell));
          if (got.order_quantity !== want.order_quantity)
            report_mismatch("order_quantity", 64'(got.order_quantity),
                            64'(want.order_quantity));
          if (got.order_price !== want.order_price)
            report_mismatch("order_price", 64'(got.order_price), 64'(want.order_price));
        end
        stall_left = calm ? 0 : $urandom_range(0, 8);
      end
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        ord_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        ord_ch.ready <= 1'b0;
      end else begin
        ord_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no word moving anywhere
  always @(posedge clk) begin
    if (!rst) begin
      if ((pkt_ch.valid && pkt_ch.ready) || (ord_ch.valid && ord_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic void send(input vwap_pkg::packet_t p);
    packet_queue.push_back(p);
    packets_sent++;
  endfunction

  function automatic vwap_pkg::packet_t quote_pkt(input logic [63:0] sym,
                                                  input logic [63:0] ts,
                                                  input logic [31:0] bq, input logic [31:0] bp,
                                                  input logic [31:0] aq, input logic [31:0] ap);
    vwap_pkg::packet_t p;
    p.packet_length    = 8'($urandom_range(1, 255));
    p.packet_type      = vwap_pkg::PKT_QUOTE;
    p.packet_symbol    = sym;
    p.packet_timestamp = ts;
    p.quote_bid_size   = bq;
    p.quote_bid_px     = bp;
    p.quote_ask_size   = aq;
    p.quote_ask_px     = ap;
    p.trade_quantity   = $urandom;
    p.trade_price      = $urandom;
    return p;
  endfunction

  function automatic vwap_pkg::packet_t trade_pkt(input logic [63:0] sym,
                                                  input logic [63:0] ts,
                                                  input logic [7:0] kind, input logic [31:0] px,
                                                  input logic [31:0] qty);
    vwap_pkg::packet_t p;
    p.packet_length    = 8'($urandom_range(1, 255));
    p.packet_type      = kind;
    p.packet_symbol    = sym;
    p.packet_timestamp = ts;
    p.quote_bid_size   = $urandom;
    p.quote_bid_px     = $urandom;
    p.quote_ask_size   = $urandom;
    p.quote_ask_px     = $urandom;
    p.trade_quantity   = qty;
    p.trade_price      = px;
    return p;
  endfunction

  function automatic logic [31:0] some_qty();
    return ($urandom_range(0, 9) == 0) ? 32'($urandom) : 32'($urandom_range(0, 20));
  endfunction

  // prices cluster around the phase's mid so both sides of the vwap test occur
  function automatic logic [31:0] near_price(input logic [31:0] mid);
    if ($urandom_range(0, 19) == 0) return $urandom;
    return mid + 32'($urandom_range(0, 40)) - 32'd20;
  endfunction

  function automatic vwap_pkg::packet_t make_packet(input logic [63:0] sym,
                                                    input logic [31:0] mid);
    vwap_pkg::packet_t p;
    int unsigned roll;
    logic [7:0]  kind;
    roll = $urandom_range(0, 99);
    if (roll < 6) p.packet_symbol = rand64();
    else if (roll < 12) p.packet_symbol = sym ^ (64'd1 << $urandom_range(0, 63));
    else p.packet_symbol = sym;
    // occasional jump anywhere, including backward in time
    if ($urandom_range(0, 99) < 3) stamp_now = rand64();
    else stamp_now = stamp_now + rand64() % (ts_span + 64'd1);
    p.packet_timestamp = stamp_now;
    if ($urandom_range(0, 99) < 45) begin
      kind = vwap_pkg::PKT_QUOTE;
    end else begin
      do kind = 8'($urandom_range(0, 255)); while (kind == vwap_pkg::PKT_QUOTE);
    end
    p.packet_type    = kind;
    p.packet_length  = ($urandom_range(0, 99) < 5) ? 8'd0 : 8'($urandom_range(1, 255));
    p.quote_bid_size = some_qty();
    p.quote_bid_px   = near_price(mid);
    p.quote_ask_size = some_qty();
    p.quote_ask_px   = near_price(mid);
    p.trade_quantity = some_qty();
    p.trade_price    = near_price(mid);
    return p;
  endfunction

  task automatic load_config(input logic [63:0] sym, input logic side,
                             input logic [31:0] cap, input logic [31:0] secs);
    logic [vwap_pkg::REG_IDX_W-1:0] idx [4];
    logic [63:0]                    val [4];
    idx = '{vwap_pkg::REG_TRACKED_SYMBOL, vwap_pkg::REG_ORDER_SIDE,
            vwap_pkg::REG_ORDER_SIZE_CAP, vwap_pkg::REG_WINDOW_SECONDS};
    val = '{sym, 64'(side), 64'(cap), 64'(secs)};
    for (int i = 0; i < 4; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.data  <= {idx[i], val[i]};
      do @(posedge clk); while (!cfg_ch.ready);
      case (idx[i])
        vwap_pkg::REG_TRACKED_SYMBOL: trk_symbol = val[i];
        vwap_pkg::REG_ORDER_SIDE:     sell_side  = val[i][0];
        vwap_pkg::REG_ORDER_SIZE_CAP: qty_cap    = val[i][31:0];
        vwap_pkg::REG_WINDOW_SECONDS:
          window_ns = 64'(val[i][31:0]) * 64'(vwap_pkg::NS_PER_SECOND);
        default: ;
      endcase
    end
    cfg_ch.valid <= 1'b0;
    ts_span = (window_ns == 64'd0) ? 64'd1000 : window_ns / 3;
  endtask

  // wait until every packet is in, every order is out, and the pipe is empty
  task automatic drain();
    while (packets_taken != packets_sent || expected_orders.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic random_phase(input logic [63:0] sym, input logic side,
                              input logic [31:0] cap, input logic [31:0] secs,
                              input logic [31:0] mid, input bit quiet, input bit squeeze,
                              input int count);
    load_config(sym, side, cap, secs);
    calm = quiet;
    for (int i = 0; i < count; i++) send(make_packet(sym, mid));
    if (squeeze) hold_request = 1'b1;
    drain();
  endtask

  initial begin
    vwap_pkg::packet_t p;
    logic [63:0]       sym;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset settings: symbol zero, buy, cap zero, zero window
    p = trade_pkt(64'd0, 64'd500, 8'd0, 32'd100, 32'd3);
    p.packet_length = 8'd0;
    send(p);
    send(quote_pkt(64'd0, 64'd1000, 32'd10, 32'd100, 32'd5, 32'd90));
    send(trade_pkt(64'd0, 64'd2000, 8'd0, 32'd100, 32'd3));
    send(trade_pkt('1, 64'd3000, 8'hFF, 32'd100, 32'd3));
    send(quote_pkt(64'd0, 64'd4000, 32'd1, 32'd1, 32'd0, 32'd0));
    send(trade_pkt(64'd0, 64'd5000, 8'd2, 32'd50, 32'd1));
    drain();

    // widest window, price-volume sum driven into saturation, timestamp wrap
    sym = 64'h4142_4344_4546_4748;
    load_config(sym, vwap_pkg::SIDE_SELL, '1, '1);
    send(quote_pkt(sym, 64'd10, 32'd0, 32'd500, 32'd9, 32'd1));
    send(trade_pkt(sym, 64'd20, 8'h00, '1, '1));
    send(trade_pkt(sym, 64'd30, 8'hFF, '1, '1));
    send(trade_pkt(sym, 64'd40, 8'h02, '1, '1));
    send(quote_pkt(sym, 64'd50, '1, '1, 32'd9, 32'd1));
    send(trade_pkt(sym, '1, 8'h80, 32'd1, 32'd1));
    send(trade_pkt(sym, 64'd5, 8'h7E, 32'd1, 32'd1));
    drain();

    // small cap eats the held bid quantity over several windows
    load_config(sym, vwap_pkg::SIDE_SELL, 32'd3, 32'd0);
    send(quote_pkt(sym, 64'd100, 32'd10, 32'd50, 32'd10, 32'd60));
    send(trade_pkt(sym, 64'd101, 8'h03, 32'd50, 32'd2));
    for (int i = 0; i < 5; i++)
      send(trade_pkt(sym, 64'd102 + 64'(i), 8'h03, 32'd40, 32'd2));
    drain();

    random_phase(rand64(), vwap_pkg::SIDE_BUY, $urandom_range(0, 20), 32'd0, 32'd1000,
                 1'b0, 1'b0, 250);
    random_phase(64'h5152_5354_5556_5758, vwap_pkg::SIDE_SELL, 32'd5, 32'd1, $urandom,
                 1'b1, 1'b0, 250);
    random_phase('1, vwap_pkg::SIDE_BUY, '1, 32'd2, 32'd30, 1'b0, 1'b0, 250);
    random_phase(64'd0, vwap_pkg::SIDE_SELL, 32'd0, 32'd0, 32'd500, 1'b1, 1'b1, 250);
    random_phase(rand64(), vwap_pkg::SIDE_SELL, $urandom, 32'd3, 32'hFFFF_FFE0,
                 1'b0, 1'b0, 250);
    random_phase(rand64(), vwap_pkg::SIDE_BUY, 32'd1, 32'd0, $urandom, 1'b1, 1'b0, 250);
    random_phase(rand64(), vwap_pkg::SIDE_BUY, 32'd7, '1, 32'd800, 1'b0, 1'b0, 200);
    random_phase(rand64(), vwap_pkg::SIDE_SELL, $urandom_range(0, 20), 32'd1, 32'd25,
                 1'b0, 1'b0, 300);

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/vwap_pkg.sv
rtl/vwap_chan_if.sv
rtl/vwap_window_order_trigger_unit.sv
tb/testbench.sv
